[rtl/core/gbalu_pkg.sv]
// Package for the Game Boy CPU ALU: operation codes, field widths, DAA constants and the flag struct.
// Has no dependencies; used by gb_cpu_alu_flags and tb_top.
package gbalu_pkg;

	localparam int unsigned OP_W   = 5;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned BYTE_W = 8;

	localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
	localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
	localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
	localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
	localparam logic [OP_W-1:0] OP_AND   = 5'd4;
	localparam logic [OP_W-1:0] OP_XOR   = 5'd5;
	localparam logic [OP_W-1:0] OP_OR    = 5'd6;
	localparam logic [OP_W-1:0] OP_CP    = 5'd7;
	localparam logic [OP_W-1:0] OP_INC   = 5'd8;
	localparam logic [OP_W-1:0] OP_DEC   = 5'd9;
	localparam logic [OP_W-1:0] OP_RLCA  = 5'd10;
	localparam logic [OP_W-1:0] OP_RRCA  = 5'd11;
	localparam logic [OP_W-1:0] OP_RLA   = 5'd12;
	localparam logic [OP_W-1:0] OP_RRA   = 5'd13;
	localparam logic [OP_W-1:0] OP_DAA   = 5'd14;
	localparam logic [OP_W-1:0] OP_CPL   = 5'd15;
	localparam logic [OP_W-1:0] OP_SCF   = 5'd16;
	localparam logic [OP_W-1:0] OP_CCF   = 5'd17;
	localparam logic [OP_W-1:0] OP_ADD16 = 5'd18;

	localparam logic [BYTE_W-1:0] DAA_HI_CORR = 8'h60;
	localparam logic [BYTE_W-1:0] DAA_LO_CORR = 8'h06;
	localparam logic [BYTE_W-1:0] DAA_HI_LIM  = 8'h99;
	localparam logic [3:0]        DAA_LO_LIM  = 4'd9;

	typedef struct packed {
		logic zero;
		logic subtract;
		logic half_carry;
		logic carry;
	} flags_t;

endpackage

[rtl/core/gb_cpu_alu_flags.sv]
// Game Boy CPU ALU with flag generation, input register and result register.
// Depends on gbalu_pkg for operation codes and the flag struct.
//
// Usage:
// The input channel (in_valid, in_stall) carries one operation per transaction:
// req_type, the operands a_value and b_value, and the incoming Z, N, H, C flags.
// The output channel (out_valid, out_stall) carries one result per transaction:
// result_value and the new flags. Eight-bit operations use the low operand bytes
// and return zero in the upper result byte; ADD16 uses all 16 bits. Unused
// operation codes pass a_value and the flags through unchanged.
// A transaction accepted into the input register moves on into the result register,
// where out_valid rises, once that register is free or the receiver takes its result.
// Throughput is one transaction per cycle while the receiver does not stall; the path
// between the two registers holds the byte, nibble and 16-bit adders plus selection.
// When the receiver stalls, the result register holds and the input register
// still fills, so one more transaction is taken before in_stall rises.
// Reset clears both valid flags; no results are pending after reset.
module gb_cpu_alu_flags
	import gbalu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   req_type,
	input  logic [WORD_W-1:0] a_value,
	input  logic [WORD_W-1:0] b_value,
	input  logic              zero_in,
	input  logic              subtract_in,
	input  logic              half_carry_in,
	input  logic              carry_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] result_value,
	output logic              zero_out,
	output logic              subtract_out,
	output logic              half_carry_out,
	output logic              carry_out
);

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;
	flags_t            flags_s1;

	logic              valid_s2;
	logic [WORD_W-1:0] res_s2;
	flags_t            flags_s2;

	logic adv_s2;
	logic adv_s1;

	logic [BYTE_W-1:0] a8;
	logic [BYTE_W-1:0] b8;
	logic              cin;
	logic [BYTE_W:0]   sum9;
	logic [4:0]        sum5;
	logic [BYTE_W:0]   dif9;
	logic [4:0]        dif5;
	logic [WORD_W:0]   sum17;
	logic [12:0]       sum13;
	logic [BYTE_W-1:0] daa_r1;
	logic [BYTE_W-1:0] daa_r;
	logic              daa_c;
	logic [WORD_W-1:0] res_c;
	flags_t            flags_c;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1    <= req_type;
			a_s1     <= a_value;
			b_s1     <= b_value;
			flags_s1 <= '{zero: zero_in, subtract: subtract_in,
				half_carry: half_carry_in, carry: carry_in};
		end
	end

	assign a8  = a_s1[BYTE_W-1:0];
	assign b8  = b_s1[BYTE_W-1:0];
	assign cin = ((op_s1 == OP_ADC) || (op_s1 == OP_SBC)) ? flags_s1.carry : 1'b0;

	assign sum9  = {1'b0, a8} + {1'b0, b8} + {{BYTE_W{1'b0}}, cin};
	assign sum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
	assign dif9  = {1'b0, a8} - {1'b0, b8} - {{BYTE_W{1'b0}}, cin};
	assign dif5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
	assign sum17 = {1'b0, a_s1} + {1'b0, b_s1};
	assign sum13 = {1'b0, a_s1[11:0]} + {1'b0, b_s1[11:0]};

	always_comb begin
		daa_c  = flags_s1.carry;
		daa_r1 = a8;
		daa_r  = a8;
		if (!flags_s1.subtract) begin
			if (flags_s1.carry || (a8 > DAA_HI_LIM)) begin
				daa_r1 = a8 + DAA_HI_CORR;
				daa_c  = 1'b1;
			end
			if (flags_s1.half_carry || (a8[3:0] > DAA_LO_LIM)) begin
				daa_r = daa_r1 + DAA_LO_CORR;
			end else begin
				daa_r = daa_r1;
			end
		end else begin
			if (flags_s1.carry) begin
				daa_r1 = a8 - DAA_HI_CORR;
			end
			if (flags_s1.half_carry) begin
				daa_r = daa_r1 - DAA_LO_CORR;
			end else begin
				daa_r = daa_r1;
			end
		end
	end

	always_comb begin
		res_c   = a_s1;
		flags_c = flags_s1;
		case (op_s1) inside
			OP_ADD, OP_ADC: begin
				res_c              = {8'd0, sum9[BYTE_W-1:0]};
				flags_c.zero       = (sum9[BYTE_W-1:0] == '0);
				flags_c.subtract   = 1'b0;
				flags_c.half_carry = sum5[4];
				flags_c.carry      = sum9[BYTE_W];
			end
			OP_SUB, OP_SBC, OP_CP: begin
				res_c              = (op_s1 == OP_CP) ? {8'd0, a8} : {8'd0, dif9[BYTE_W-1:0]};
				flags_c.zero       = (dif9[BYTE_W-1:0] == '0);
				flags_c.subtract   = 1'b1;
				flags_c.half_carry = dif5[4];
				flags_c.carry      = dif9[BYTE_W];
			end
			OP_AND: begin
				res_c   = {8'd0, a8 & b8};
				flags_c = '{zero: ((a8 & b8) == '0), subtract: 1'b0,
					half_carry: 1'b1, carry: 1'b0};
			end
			OP_XOR: begin
				res_c   = {8'd0, a8 ^ b8};
				flags_c = '{zero: ((a8 ^ b8) == '0), subtract: 1'b0,
					half_carry: 1'b0, carry: 1'b0};
			end
			OP_OR: begin
				res_c   = {8'd0, a8 | b8};
				flags_c = '{zero: ((a8 | b8) == '0), subtract: 1'b0,
					half_carry: 1'b0, carry: 1'b0};
			end
			OP_INC: begin
				res_c              = {8'd0, a8 + 8'd1};
				flags_c.zero       = (a8 == 8'hFF);
				flags_c.subtract   = 1'b0;
				flags_c.half_carry = (a8[3:0] == 4'hF);
			end
			OP_DEC: begin
				res_c              = {8'd0, a8 - 8'd1};
				flags_c.zero       = (a8 == 8'h01);
				flags_c.subtract   = 1'b1;
				flags_c.half_carry = (a8[3:0] == 4'h0);
			end
			OP_RLCA: begin
				res_c   = {8'd0, a8[6:0], a8[7]};
				flags_c = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a8[7]};
			end
			OP_RRCA: begin
				res_c   = {8'd0, a8[0], a8[7:1]};
				flags_c = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a8[0]};
			end
			OP_RLA: begin
				res_c   = {8'd0, a8[6:0], flags_s1.carry};
				flags_c = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a8[7]};
			end
			OP_RRA: begin
				res_c   = {8'd0, flags_s1.carry, a8[7:1]};
				flags_c = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a8[0]};
			end
			OP_DAA: begin
				res_c              = {8'd0, daa_r};
				flags_c.zero       = (daa_r == '0);
				flags_c.half_carry = 1'b0;
				flags_c.carry      = daa_c;
			end
			OP_CPL: begin
				res_c              = {8'd0, ~a8};
				flags_c.subtract   = 1'b1;
				flags_c.half_carry = 1'b1;
			end
			OP_SCF: begin
				res_c              = {8'd0, a8};
				flags_c.subtract   = 1'b0;
				flags_c.half_carry = 1'b0;
				flags_c.carry      = 1'b1;
			end
			OP_CCF: begin
				res_c              = {8'd0, a8};
				flags_c.subtract   = 1'b0;
				flags_c.half_carry = 1'b0;
				flags_c.carry      = !flags_s1.carry;
			end
			OP_ADD16: begin
				res_c              = sum17[WORD_W-1:0];
				flags_c.subtract   = 1'b0;
				flags_c.half_carry = sum13[12];
				flags_c.carry      = sum17[WORD_W];
			end
			default: begin
				res_c   = a_s1;
				flags_c = flags_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2   <= res_c;
			flags_s2 <= flags_c;
		end
	end

	assign out_valid      = valid_s2;
	assign result_value   = res_s2;
	assign zero_out       = flags_s2.zero;
	assign subtract_out   = flags_s2.subtract;
	assign half_carry_out = flags_s2.half_carry;
	assign carry_out      = flags_s2.carry;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("Input stalled without a blocked result.");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("Accepted transaction did not reach the input register.");

	a_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> out_valid)
		else $error("Input register content was dropped.");

	a_byte_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && (op_s1 <= OP_CCF)) |=> (result_value[15:8] == 8'd0))
		else $error("Eight-bit operation produced a nonzero upper byte.");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for gb_cpu_alu_flags, the Game Boy CPU ALU with flags.
// Depends on gbalu_pkg and the RTL only; each transaction is predicted and checked
// against the result stream under random sender gaps and receiver stalls.
module tb_top
	import gbalu_pkg::*;
();

	localparam int HOLD_CYCLES  = 60;
	localparam int TAIL_CYCLES  = 8;
	localparam int RANDOM_ITEMS = 1900;

	localparam logic [OP_W-1:0] OP_MAX_CODE = '1;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		flags_t            flags;
	} alu_result_t;

	localparam flags_t NO_FLAGS  = flags_t'(4'b0000);
	localparam flags_t ALL_FLAGS = flags_t'(4'b1111);
	localparam flags_t CARRY_SET = flags_t'(4'b0001);
	localparam flags_t HALF_SET  = flags_t'(4'b0010);
	localparam flags_t SUB_SET   = flags_t'(4'b0100);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   req_type = '0;
	logic [WORD_W-1:0] a_value = '0;
	logic [WORD_W-1:0] b_value = '0;
	logic              zero_in = 1'b0;
	logic              subtract_in = 1'b0;
	logic              half_carry_in = 1'b0;
	logic              carry_in = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] result_value;
	logic              zero_out;
	logic              subtract_out;
	logic              half_carry_out;
	logic              carry_out;

	alu_result_t pending_results[$];
	int          error_count = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          hold_off_req = 1'b0;

	gb_cpu_alu_flags uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.a_value        (a_value),
		.b_value        (b_value),
		.zero_in        (zero_in),
		.subtract_in    (subtract_in),
		.half_carry_in  (half_carry_in),
		.carry_in       (carry_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.zero_out       (zero_out),
		.subtract_out   (subtract_out),
		.half_carry_out (half_carry_out),
		.carry_out      (carry_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic alu_result_t alu_predict(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] aw, input logic [WORD_W-1:0] bw, input flags_t fin);
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  r;
		logic [8:0]  sum;
		logic [8:0]  rhs;
		logic [4:0]  nib;
		logic [4:0]  nib_rhs;
		logic [16:0] wide;
		logic [12:0] wide12;
		logic        t;
		alu_result_t res;
		a = aw[7:0];
		b = bw[7:0];
		r = 8'h00;
		res.value = '0;
		res.flags = fin;
		case (op)
			OP_ADD, OP_ADC: begin
				t = (op == OP_ADC) ? fin.carry : 1'b0;
				sum = {1'b0, a} + {1'b0, b} + {8'd0, t};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
				r = sum[7:0];
				res.flags = '{zero: (r == 8'h00), subtract: 1'b0,
					half_carry: nib[4], carry: sum[8]};
			end
			OP_SUB, OP_SBC, OP_CP: begin
				t = (op == OP_SBC) ? fin.carry : 1'b0;
				nib_rhs = {1'b0, b[3:0]} + {4'd0, t};
				rhs = {1'b0, b} + {8'd0, t};
				r = a - b - {7'd0, t};
				res.flags = '{zero: (r == 8'h00), subtract: 1'b1,
					half_carry: ({1'b0, a[3:0]} < nib_rhs), carry: ({1'b0, a} < rhs)};
				if (op == OP_CP)
					r = a;
			end
			OP_AND: begin
				r = a & b;
				res.flags = '{zero: (r == 8'h00), subtract: 1'b0, half_carry: 1'b1, carry: 1'b0};
			end
			OP_XOR, OP_OR: begin
				r = (op == OP_XOR) ? (a ^ b) : (a | b);
				res.flags = '{zero: (r == 8'h00), subtract: 1'b0, half_carry: 1'b0, carry: 1'b0};
			end
			OP_INC: begin
				r = a + 8'h01;
				res.flags.zero = (r == 8'h00);
				res.flags.subtract = 1'b0;
				res.flags.half_carry = (a[3:0] == 4'hF);
			end
			OP_DEC: begin
				r = a - 8'h01;
				res.flags.zero = (r == 8'h00);
				res.flags.subtract = 1'b1;
				res.flags.half_carry = (a[3:0] == 4'h0);
			end
			OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
				case (op)
					OP_RLCA: r = {a[6:0], a[7]};
					OP_RRCA: r = {a[0], a[7:1]};
					OP_RLA:  r = {a[6:0], fin.carry};
					default: r = {fin.carry, a[7:1]};
				endcase
				res.flags = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0,
					carry: ((op == OP_RLCA) || (op == OP_RLA)) ? a[7] : a[0]};
			end
			OP_DAA: begin
				r = a;
				if (!fin.subtract) begin
					if (fin.carry || (a > 8'h99)) begin
						r = r + 8'h60;
						res.flags.carry = 1'b1;
					end
					if (fin.half_carry || (r[3:0] > 4'd9))
						r = r + 8'h06;
				end else begin
					if (fin.carry)
						r = r - 8'h60;
					if (fin.half_carry)
						r = r - 8'h06;
				end
				res.flags.zero = (r == 8'h00);
				res.flags.half_carry = 1'b0;
			end
			OP_CPL: begin
				r = ~a;
				res.flags.subtract = 1'b1;
				res.flags.half_carry = 1'b1;
			end
			OP_SCF, OP_CCF: begin
				r = a;
				res.flags.subtract = 1'b0;
				res.flags.half_carry = 1'b0;
				res.flags.carry = (op == OP_SCF) ? 1'b1 : ~fin.carry;
			end
			default: ;
		endcase
		if (op == OP_ADD16) begin
			wide = {1'b0, aw} + {1'b0, bw};
			wide12 = {1'b0, aw[11:0]} + {1'b0, bw[11:0]};
			res.value = wide[15:0];
			res.flags.subtract = 1'b0;
			res.flags.half_carry = wide12[12];
			res.flags.carry = wide[16];
		end else if (op > OP_ADD16) begin
			res.value = aw;
		end else begin
			res.value = {8'h00, r};
		end
		return res;
	endfunction

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom) | 16'h0F0F;
			3: return 16'($urandom) & 16'hF0F0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic flags_t pick_flags();
		return flags_t'(4'($urandom_range(0, 15)));
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		error_count++;
	endtask

	// Drives one operation and waits for its transaction; called at a rising edge.
	task automatic issue_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input flags_t f);
		int gap;
		gap = tx_quiet ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= op;
		a_value       <= a;
		b_value       <= b;
		zero_in       <= f.zero;
		subtract_in   <= f.subtract;
		half_carry_in <= f.half_carry;
		carry_in      <= f.carry;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(alu_predict(op, a, b, f));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int run;
		run = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				run = 0;
				out_stall <= 1'b0;
			end else if (run > 0) begin
				out_stall <= 1'b1;
				run--;
			end else begin
				out_stall <= 1'b0;
				if (!rx_quiet && ($urandom_range(0, 3) == 0))
					run = idle_len();
			end
		end
	end

	initial begin
		alu_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", result_value));
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.value)
						report_mismatch($sformatf("result_value %h, want %h",
							result_value, want.value));
					if (zero_out !== want.flags.zero)
						report_mismatch($sformatf("zero_out %b, want %b",
							zero_out, want.flags.zero));
					if (subtract_out !== want.flags.subtract)
						report_mismatch($sformatf("subtract_out %b, want %b",
							subtract_out, want.flags.subtract));
					if (half_carry_out !== want.flags.half_carry)
						report_mismatch($sformatf("half_carry_out %b, want %b",
							half_carry_out, want.flags.half_carry));
					if (carry_out !== want.flags.carry)
						report_mismatch($sformatf("carry_out %b, want %b",
							carry_out, want.flags.carry));
				end
			end
		end
	end

	task automatic test_add_sub();
		issue_op(OP_ADD, 16'h0000, 16'h0000, ALL_FLAGS);
		issue_op(OP_ADD, 16'hAAFF, 16'h5501, NO_FLAGS);
		issue_op(OP_ADC, 16'h000F, 16'h0000, CARRY_SET);
		issue_op(OP_ADC, 16'h00FF, 16'h00FF, CARRY_SET);
		issue_op(OP_SBC, 16'h0010, 16'h000F, CARRY_SET);
		issue_op(OP_CP,  16'hFF00, 16'h00FF, NO_FLAGS);
	endtask

	task automatic test_logic();
		issue_op(OP_AND, 16'h00FF, 16'hFF00, NO_FLAGS);
		issue_op(OP_XOR, 16'h12AA, 16'h34AA, ALL_FLAGS);
		issue_op(OP_OR,  16'hFFF0, 16'h000F, ALL_FLAGS);
	endtask

	task automatic test_inc_dec();
		issue_op(OP_INC, 16'hFFFF, 16'h0000, CARRY_SET);
		issue_op(OP_INC, 16'h000F, 16'h0000, NO_FLAGS);
		issue_op(OP_DEC, 16'h0000, 16'hFFFF, NO_FLAGS);
		issue_op(OP_DEC, 16'h0001, 16'h0000, ALL_FLAGS);
	endtask

	task automatic test_rotates();
		issue_op(OP_RLCA, 16'h0080, 16'h0000, ALL_FLAGS);
		issue_op(OP_RRCA, 16'hFF01, 16'h0000, NO_FLAGS);
		issue_op(OP_RLA,  16'h0080, 16'h0000, NO_FLAGS);
		issue_op(OP_RRA,  16'h0000, 16'h0000, CARRY_SET);
	endtask

	task automatic test_daa();
		issue_op(OP_DAA, 16'h009A, 16'h0000, NO_FLAGS);
		issue_op(OP_DAA, 16'h00FF, 16'h0000, ALL_FLAGS);
	endtask

	task automatic test_flag_ops();
		issue_op(OP_CPL, 16'hAB00, 16'h0000, NO_FLAGS);
		issue_op(OP_SCF, 16'h1234, 16'h0000, SUB_SET | HALF_SET);
		issue_op(OP_CCF, 16'hFFFF, 16'h0000, CARRY_SET);
	endtask

	task automatic test_add16();
		issue_op(OP_ADD16, 16'hFFFF, 16'h0001, NO_FLAGS);
		issue_op(OP_ADD16, 16'h0FFF, 16'h0001, ALL_FLAGS);
	endtask

	task automatic test_unused_codes();
		issue_op(OP_ADD16 + 5'd1, 16'hBEEF, 16'h1234, SUB_SET | CARRY_SET);
		issue_op(OP_MAX_CODE, 16'hFFFF, 16'hFFFF, HALF_SET);
	endtask

	task automatic test_random(input int count);
		logic [OP_W-1:0] op;
		for (int i = 0; i < count; i++) begin
			if (i % 250 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 9) == 0)
				op = OP_W'($urandom_range(OP_ADD16 + 1, OP_MAX_CODE));
			else
				op = OP_W'($urandom_range(OP_ADD, OP_ADD16));
			issue_op(op, pick_word(), pick_word(), pick_flags());
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		tx_quiet = 1'b1;
		hold_off_req = 1'b1;
		for (int i = 0; i < 40; i++)
			issue_op(OP_W'($urandom_range(OP_ADD, OP_ADD16)), pick_word(), pick_word(),
				pick_flags());
		tx_quiet = 1'b0;
	endtask

	task automatic test_pause_until_idle();
		wait_idle();
		for (int i = 0; i < 10; i++)
			issue_op(OP_W'($urandom_range(OP_ADD, OP_ADD16)), pick_word(), pick_word(),
				pick_flags());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_sub();
		test_logic();
		test_inc_dec();
		test_rotates();
		test_daa();
		test_flag_ops();
		test_add16();
		test_unused_codes();
		test_backpressure();
		test_pause_until_idle();
		test_random(RANDOM_ITEMS);
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
